[rtl/bci_pkg.sv]
package bci_pkg;

  // arithmetic unit operations
  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_K_ABOVE  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic start;
    logic op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

endpackage

[rtl/bci_arith.sv]
module bci_arith
  import bci_pkg::*;
#(
  parameter int W  = 32,
  parameter int O  = 16,
  parameter int PW = W + O
) (
  input  logic          clk,
  input  logic          rst,
  input  arith_req_t    req,
  input  logic [W-1:0]  a,
  input  logic [W-1:0]  b,
  output arith_rsp_t    rsp,
  output logic [W-1:0]  quot,
  output logic [W-1:0]  rem,
  output logic [PW-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic          done;
  logic          op_r;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dq;
  logic [W-1:0]  rm;
  logic [W-1:0]  dvs;
  logic [W-1:0]  mc;
  logic [O-1:0]  mb;
  logic [PW-1:0] acc;
  logic [W:0]    trial;
  logic [PW-1:0] addend;

  // restoring division: one quotient bit per cycle
  assign trial  = {rm, dq[W-1]} - {1'b0, dvs};
  // shift-add multiply, multiplier bits msb first
  assign addend = mb[O-1] ? PW'(mc) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      cnt  <= (req.op == OP_MUL) ? CW'(O) : CW'(W);
      dq   <= a;
      rm   <= '0;
      dvs  <= b;
      mc   <= a;
      mb   <= b[O-1:0];
      acc  <= '0;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (op_r == OP_MUL) begin
        acc <= {acc[PW-2:0], 1'b0} + addend;
        mb  <= {mb[O-2:0], 1'b0};
      end else begin
        if (!trial[W]) begin
          rm <= trial[W-1:0];
        end else begin
          rm <= {rm[W-2:0], dq[W-1]};
        end
        dq <= {dq[W-2:0], ~trial[W]};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign quot     = dq;
  assign rem      = rm;
  assign prod     = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("arith started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("arith done while still busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (busy && op_r == OP_DIV) |-> dvs != '0) else $error("division by zero");

endmodule

[rtl/binomial_coefficient_integer.sv]
// The shared arithmetic unit is W = max(RESULT_BITS, OPERAND_BITS) bits wide.
// A step costs one division, a second one if not exact, and one or two multiplies.
// All work runs on one shared shift-subtract / shift-add unit; k above n skips the unit.
// One item at a time: s_tready is high only in idle, from the cycle after the result is loaded.
// Reset (rst, synchronous) clears the sequencer and drops m_tvalid; data is not cleared.
module binomial_coefficient_integer
  import bci_pkg::*;
#(
  parameter int RESULT_BITS  = 32,
  parameter int OPERAND_BITS = 16,
  localparam int IN_W  = ((2 * OPERAND_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((RESULT_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // n_value, k_value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // coefficient, status
);

  localparam int R  = RESULT_BITS;
  localparam int O  = OPERAND_BITS;
  localparam int W  = (R > O) ? R : O;
  localparam int PW = W + O;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVT = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_MULQ = 3'd3;
  localparam logic [2:0] S_MULT = 3'd4;
  localparam logic [2:0] S_MULD = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state;
  logic          go;
  logic          need_den;
  logic [O-1:0]  top;
  logic [O-1:0]  bot;
  logic [R-1:0]  num;
  logic [R-1:0]  den;
  logic [R-1:0]  res_coef;
  logic [1:0]    res_stat;
  logic [R-1:0]  coefficient;
  logic [1:0]    status;

  logic [O-1:0]  n_value;
  logic [O-1:0]  k_value;
  logic [O-1:0]  n_minus_k;
  logic [O-1:0]  m_steps;
  logic          work;
  logic          mul_state;
  logic          mul_ovf;
  logic          last_step;

  arith_req_t    req;
  arith_rsp_t    rsp;
  logic [W-1:0]  op_a;
  logic [W-1:0]  op_b;
  logic [W-1:0]  quot;
  logic [W-1:0]  rem;
  logic [PW-1:0] prod;

  assign n_value   = s_tdata[O-1:0];
  assign k_value   = s_tdata[2*O-1:O];
  assign n_minus_k = n_value - k_value;
  assign m_steps   = (k_value < n_minus_k) ? k_value : n_minus_k;

  assign s_tready  = (state == S_IDLE);
  assign mul_state = (state == S_MULQ) || (state == S_MULT) || (state == S_MULD);
  assign work      = (state != S_IDLE) && (state != S_DONE);
  assign req.start = work && !go;
  assign req.op    = mul_state ? OP_MUL : OP_DIV;
  assign mul_ovf   = (prod[PW-1:R] != '0);
  assign last_step = (bot == O'(1));

  always_comb begin
    case (state)
      S_DIVT:  begin op_a = W'(top); op_b = W'(bot);                end
      S_DIVN:  begin op_a = W'(num); op_b = W'(bot);                end
      S_MULQ:  begin op_a = W'(num); op_b = W'(quot[O-1:0]);        end
      S_MULT:  begin op_a = W'(num); op_b = W'(top);                end
      S_MULD:  begin op_a = W'(den); op_b = W'(bot);                end
      S_FIN:   begin op_a = W'(num); op_b = W'(den);                end
      default: begin op_a = '0;      op_b = '0;                     end
    endcase
  end

  bci_arith #(.W(W), .O(O), .PW(PW)) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (op_a),
    .b    (op_b),
    .rsp  (rsp),
    .quot (quot),
    .rem  (rem),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      go       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE reloads the output word itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (req.start) begin
        go <= 1'b1;
      end else if (rsp.done) begin
        go <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            top      <= n_value;
            bot      <= m_steps;
            num      <= R'(1);
            den      <= R'(1);
            need_den <= 1'b0;
            res_coef <= '0;
            if (k_value > n_value) begin
              res_stat <= ST_K_ABOVE;
              state    <= S_DONE;
            end else begin
              res_stat <= ST_OK;
              state    <= (m_steps == '0) ? S_FIN : S_DIVT;
            end
          end
        end
        S_DIVT: begin
          if (rsp.done) begin
            need_den <= 1'b0;
            state    <= (rem == '0) ? S_MULQ : S_DIVN;
          end
        end
        S_DIVN: begin
          if (rsp.done) begin
            // cancel now if the accumulator divides, else defer to den
            if (rem == '0) begin
              num <= quot[R-1:0];
            end else begin
              need_den <= 1'b1;
            end
            state <= S_MULT;
          end
        end
        S_MULQ, S_MULT, S_MULD: begin
          if (rsp.done) begin
            if (mul_ovf) begin
              res_stat <= ST_OVERFLOW;
              state    <= S_DONE;
            end else begin
              if (state == S_MULD) begin
                den <= prod[R-1:0];
              end else begin
                num <= prod[R-1:0];
              end
              if (state == S_MULT && need_den) begin
                state <= S_MULD;
              end else begin
                top   <= top - O'(1);
                bot   <= bot - O'(1);
                state <= last_step ? S_FIN : S_DIVT;
              end
            end
          end
        end
        S_FIN: begin
          if (rsp.done) begin
            res_coef <= quot[R-1:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            coefficient <= (res_stat == ST_OK) ? res_coef : '0;
            status      <= res_stat;
            m_tvalid    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_W'({status, coefficient});

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |-> coefficient == '0)
    else $error("nonzero coefficient with error status");

  a_bot_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVT || state == S_DIVN || state == S_MULD) |-> bot != '0)
    else $error("step divisor is zero");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> den != '0) else $error("final divisor is zero");

  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (go && work)) else $error("arith done without a pending request");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import bci_pkg::*;
();

  typedef struct packed {
    logic [31:0] coefficient;
    logic [1:0]  status;
  } coef_result_t;

  // Predicts C(n,k) for every accepted operand pair and checks the returned words in order.
  class binom_scoreboard;
    localparam longint unsigned COEF_MAX = 64'h0000_0000_FFFF_FFFF;

    coef_result_t pending_coeffs[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit product_fits(longint unsigned acc, longint unsigned f);
      return (f == 0) || (acc <= COEF_MAX / f);
    endfunction

    function coef_result_t binom_value(logic [15:0] n_in, logic [15:0] k_in);
      longint unsigned n, k, m, i, top, bot, num, den;
      coef_result_t r;
      n = n_in;
      k = k_in;
      num = 1;
      den = 1;
      r.coefficient = '0;
      r.status = ST_OK;
      if (k > n) begin
        r.status = ST_K_ABOVE;
        return r;
      end
      if (k == 0) begin
        r.coefficient = 32'd1;
        return r;
      end
      if (k == 1) begin
        if (n > COEF_MAX) r.status = ST_OVERFLOW;
        else r.coefficient = 32'(n);
        return r;
      end
      m = (k < n - k) ? k : n - k;
      // num at least doubles each step, so overflow ends the loop within ~32 steps
      for (i = 0; i < m; i++) begin
        top = n - i;
        bot = m - i;
        if (top % bot == 0) begin
          if (!product_fits(num, top / bot)) begin
            r.status = ST_OVERFLOW;
            return r;
          end
          num = num * (top / bot);
        end else if (num % bot == 0) begin
          num = num / bot;
          if (!product_fits(num, top)) begin
            r.status = ST_OVERFLOW;
            return r;
          end
          num = num * top;
        end else begin
          if (!product_fits(num, top)) begin
            r.status = ST_OVERFLOW;
            return r;
          end
          num = num * top;
          if (!product_fits(den, bot)) begin
            r.status = ST_OVERFLOW;
            return r;
          end
          den = den * bot;
        end
      end
      r.coefficient = 32'(num / den);
      return r;
    endfunction

    function void note_operands(logic [15:0] n_in, logic [15:0] k_in);
      pending_coeffs.push_back(binom_value(n_in, k_in));
    endfunction

    function void check_result(logic [31:0] coef, logic [1:0] st);
      coef_result_t want;
      if (pending_coeffs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, coefficient %0d status %0d", $time, coef, st);
        return;
      end
      want = pending_coeffs.pop_front();
      if (coef !== want.coefficient) begin
        mismatches++;
        $display("%0t: coefficient expected %0d actual %0d", $time, want.coefficient, coef);
      end
      if (st !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
    endfunction
  endclass

  localparam int RANDOM_PAIRS   = 330;
  localparam int QUIET_TAIL     = 50;
  localparam int HOLD_AFTER     = 60;
  localparam int HOLD_CYCLES    = 4000;
  localparam int STALL_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // n_value, k_value
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // coefficient, status

  binom_scoreboard board;
  int unsigned     words_sent;
  bit              quiet_tail;
  bit              hold_done;
  int unsigned     idle_cycles;

  binomial_coefficient_integer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // offers one operand pair from a falling edge, returns at the falling edge after acceptance
  task automatic send_pair(logic [15:0] n_in, logic [15:0] k_in);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {k_in, n_in};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_operands(n_in, k_in);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata[31:0], m_tdata[33:32]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] dir_n [0:21];
    logic [15:0] dir_k [0:21];
    logic [15:0] n_val, k_val;
    int          j;

    dir_n = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
              16'd65535, 16'd65535, 16'd5, 16'd0, 16'd32768, 16'd34, 16'd35, 16'd33,
              16'd10, 16'd20, 16'd1, 16'd2, 16'd100, 16'd40, 16'd65534};
    dir_k = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd65535, 16'd2, 16'd3, 16'd32768,
              16'd65534, 16'd7, 16'd65535, 16'd32769, 16'd17, 16'd17, 16'd16,
              16'd5, 16'd10, 16'd1, 16'd1, 16'd50, 16'd3, 16'd32767};

    board       = new();
    words_sent  = 0;
    quiet_tail  = 1'b0;
    hold_done   = 1'b0;
    idle_cycles = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // extremes, k above n, overflow edges, k near n, mid-size exact cases
    for (j = 0; j < 22; j++) send_pair(dir_n[j], dir_k[j]);

    for (j = 0; j < RANDOM_PAIRS; j++) begin
      if (j >= RANDOM_PAIRS - QUIET_TAIL) quiet_tail = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // small n: most results complete without overflow
          n_val = 16'($urandom_range(0, 70));
          k_val = 16'($urandom_range(0, n_val + 2));
        end
        6, 7: begin
          n_val = 16'($urandom);
          if ($urandom_range(0, 1) == 0) k_val = 16'($urandom_range(0, 4));
          else k_val = n_val - 16'($urandom_range(0, 4));
        end
        default: begin
          n_val = 16'($urandom);
          k_val = 16'($urandom);
        end
      endcase
      send_pair(n_val, k_val);
    end
    s_tvalid = 1'b0;

    while (board.pending_coeffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
